/* hdl/assert_macros.svh */
// assertion macros shared by the planar pose transform rtl
// no dependencies; files that assert include this header by name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked check that also runs through reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/ppt_pkg.sv */
// shared constants and types for the planar pose transform
// no dependencies; imported by ppt_cordic and planar_pose_transform_unit
package ppt_pkg;

    // default parameter values
    localparam int POS_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // fixed widths
    localparam int ANG_WIDTH    = 19;
    localparam int TRIG_W       = 32;
    localparam int CORDIC_STEPS = 28;
    localparam int TRIG_SHIFT   = 28;

    // angle and gain constants in Q2.28
    localparam longint PI_Q28          = 64'sd843314857;
    localparam longint HALF_PI_Q28     = 64'sd421657428;
    localparam longint CORDIC_GAIN_Q28 = 64'sd163008219;

    // arctangent of 2^-i in Q2.28
    localparam longint ATAN_Q28 [CORDIC_STEPS] = '{
        64'sd210828714, 64'sd124459457, 64'sd65760959, 64'sd33381290,
        64'sd16755422, 64'sd8385879, 64'sd4193963, 64'sd2097109,
        64'sd1048571, 64'sd524287, 64'sd262144, 64'sd131072,
        64'sd65536, 64'sd32768, 64'sd16384, 64'sd8192,
        64'sd4096, 64'sd2048, 64'sd1024, 64'sd512,
        64'sd256, 64'sd128, 64'sd64, 64'sd32,
        64'sd16, 64'sd8, 64'sd4, 64'sd2
    };

    // request codes
    typedef logic [1:0] t_req;
    localparam t_req REQ_COMPOSE = 2'd0;
    localparam t_req REQ_BETWEEN = 2'd1;
    localparam t_req REQ_POINT   = 2'd2;
    localparam t_req REQ_RSVD    = 2'd3;

endpackage

/* hdl/ppt_cordic.sv */
// pipelined cordic rotation, one iteration per register stage, with sideband
// depends on ppt_pkg and assert_macros.svh
`include "assert_macros.svh"

module ppt_cordic
    import ppt_pkg::*;
#(
    parameter int Z_W    = 33,
    parameter int SIDE_W = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [Z_W-1:0]    i_z,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [TRIG_W-1:0] o_cos,
    output logic signed [TRIG_W-1:0] o_sin,
    output logic [SIDE_W-1:0]        o_side
);

    localparam int N = CORDIC_STEPS;
    localparam logic signed [TRIG_W-1:0] X_INIT = TRIG_W'(CORDIC_GAIN_Q28);

    // stage registers
    logic [N-1:0]              r_vld;
    logic signed [TRIG_W-1:0]  r_x    [N];
    logic signed [TRIG_W-1:0]  r_y    [N];
    logic signed [Z_W-1:0]     r_z    [N];
    logic [SIDE_W-1:0]         r_side [N];

    // stage sources and ready chain
    logic [N-1:0]              w_src_vld;
    logic [N-1:0]              w_rdy;
    logic signed [TRIG_W-1:0]  w_src_x [N];
    logic signed [TRIG_W-1:0]  w_src_y [N];
    logic signed [Z_W-1:0]     w_src_z [N];
    logic [SIDE_W-1:0]         w_src_side [N];
    logic signed [TRIG_W-1:0]  n_x [N];
    logic signed [TRIG_W-1:0]  n_y [N];
    logic signed [Z_W-1:0]     n_z [N];

    logic w_in_acc;
    logic w_out_acc;

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            // source of this stage: ports for the first, previous stage otherwise
            if (k == 0) begin : g_first
                assign w_src_vld[k]  = i_valid;
                assign w_src_x[k]    = X_INIT;
                assign w_src_y[k]    = '0;
                assign w_src_z[k]    = i_z;
                assign w_src_side[k] = i_side;
            end else begin : g_next
                assign w_src_vld[k]  = r_vld[k-1];
                assign w_src_x[k]    = r_x[k-1];
                assign w_src_y[k]    = r_y[k-1];
                assign w_src_z[k]    = r_z[k-1];
                assign w_src_side[k] = r_side[k-1];
            end

            // stage may load when empty or when its content moves on
            if (k == N - 1) begin : g_rdy_last
                assign w_rdy[k] = !r_vld[k] || i_ready;
            end else begin : g_rdy_mid
                assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
            end

            // one micro-rotation, direction from the sign of the residual angle
            always_comb begin
                if (!w_src_z[k][Z_W-1]) begin
                    n_x[k] = w_src_x[k] - (w_src_y[k] >>> k);
                    n_y[k] = w_src_y[k] + (w_src_x[k] >>> k);
                    n_z[k] = w_src_z[k] - Z_W'(ATAN_Q28[k]);
                end else begin
                    n_x[k] = w_src_x[k] + (w_src_y[k] >>> k);
                    n_y[k] = w_src_y[k] - (w_src_x[k] >>> k);
                    n_z[k] = w_src_z[k] + Z_W'(ATAN_Q28[k]);
                end
            end

            // valid bit
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (w_rdy[k]) begin
                    r_vld[k] <= w_src_vld[k];
                end
            end

            // payload
            always_ff @(posedge i_clk) begin
                if (w_rdy[k] && w_src_vld[k]) begin
                    r_x[k]    <= n_x[k];
                    r_y[k]    <= n_y[k];
                    r_z[k]    <= n_z[k];
                    r_side[k] <= w_src_side[k];
                end
            end
        end
    endgenerate

    // outputs
    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[N-1];
    assign o_cos   = r_x[N-1];
    assign o_sin   = r_y[N-1];
    assign o_side  = r_side[N-1];

    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;

    // checks
    `ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> (r_vld == '0), "cordic pipe not empty after reset")
    `ASSERT_CLK(a_occupancy, $past(i_rst_n) |-> ($countones(r_vld) == $countones($past(r_vld)) + $past(w_in_acc) - $past(w_out_acc)), "cordic pipe lost or repeated a request")
    `ASSERT_CLK(a_stall_full, !o_ready |-> ((&r_vld) && !i_ready), "cordic pipe stalls input with a bubble inside")

endmodule

/* hdl/planar_pose_transform_unit.sv */
// planar pose transform top level: compose, between and point transform on q16.16 poses
// depends on ppt_pkg, ppt_cordic and assert_macros.svh
// depth: 34 register stages
// throughput: one request per cycle sustained while i_ready is high; bubbles collapse on output stalls
// an operand prep stage and the 28 cordic iteration stages set the depth, followed by trig sign, split multiply,
// partial sum, rounding and translate/saturate stages
// reset (synchronous, active low) clears every stage valid bit; payload is not reset
`include "assert_macros.svh"

module planar_pose_transform_unit
    import ppt_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_req_type,
    input  logic signed [POS_WIDTH-1:0] i_a_x,
    input  logic signed [POS_WIDTH-1:0] i_a_y,
    input  logic signed [ANG_WIDTH-1:0] i_a_theta,
    input  logic signed [POS_WIDTH-1:0] i_b_x,
    input  logic signed [POS_WIDTH-1:0] i_b_y,
    input  logic signed [ANG_WIDTH-1:0] i_b_theta,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [POS_WIDTH-1:0] o_out_x,
    output logic signed [POS_WIDTH-1:0] o_out_y,
    output logic signed [ANG_WIDTH-1:0] o_out_theta,
    output logic                        o_saturated
);

    // derived widths
    localparam int PW    = POS_WIDTH;
    localparam int VW    = PW + 1;
    localparam int LO_W  = (VW + 1) / 2;
    localparam int HI_W  = VW - LO_W;
    localparam int ZB_W  = ANG_WIDTH + TRIG_SHIFT - FRAC_BITS;
    localparam int Z_W   = ((ZB_W > 30) ? ZB_W : 30) + 2;
    localparam int TH_W  = 30;
    localparam int PH_W  = HI_W + TRIG_W;
    localparam int PL_W  = LO_W + 1 + TRIG_W;
    localparam int H3_W  = PH_W + 1;
    localparam int L3_W  = PL_W + 2;
    localparam int ACC_W = VW + TRIG_W + 1;
    localparam int R_W   = ACC_W - TRIG_SHIFT;
    localparam int F_W   = R_W + 1;
    localparam int SIDE_W = 2 + 1 + 2 * VW + 2 * PW + TH_W;

    // constants
    localparam longint PI_FX =
        (PI_Q28 + (64'sd1 <<< (TRIG_SHIFT - 1 - FRAC_BITS))) >>> (TRIG_SHIFT - FRAC_BITS);
    localparam logic signed [Z_W-1:0]  Z_PI      = Z_W'(PI_Q28);
    localparam logic signed [Z_W-1:0]  Z_HALF_PI = Z_W'(HALF_PI_Q28);
    localparam logic signed [TH_W-1:0] TH_PI     = TH_W'(PI_FX);
    localparam logic signed [TH_W-1:0] TH_2PI    = TH_W'(2 * PI_FX);
    localparam logic signed [L3_W-1:0] L_RND     = L3_W'(64'sd1 <<< (TRIG_SHIFT - 1));
    localparam logic signed [PW-1:0]   PMAX      = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0]   PMIN      = {1'b1, {(PW-1){1'b0}}};
    localparam logic signed [F_W-1:0]  F_PMAX    = F_W'(PMAX);
    localparam logic signed [F_W-1:0]  F_PMIN    = F_W'(PMIN);

    // ready chain
    logic w_rdy0, w_c_rdy, w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy_out;

    // ------------------------------------------------------------------
    // stage 0: operand prep, heading sum or difference, half-turn reduction of the angle
    // ------------------------------------------------------------------
    logic                    r_s0_vld;
    logic signed [Z_W-1:0]   r_s0_z;
    logic [SIDE_W-1:0]       r_s0_side;

    logic signed [Z_W-1:0]   n_s0_zraw;
    logic signed [Z_W-1:0]   n_s0_z;
    logic                    n_s0_flip;
    logic signed [VW-1:0]    n_s0_v1;
    logic signed [VW-1:0]    n_s0_v2;
    logic signed [PW-1:0]    n_s0_tx;
    logic signed [PW-1:0]    n_s0_ty;
    logic signed [TH_W-1:0]  n_s0_th;

    always_comb begin
        // angle to q2.28, take off or add a half turn when beyond a quarter turn either way
        n_s0_zraw = Z_W'(i_a_theta) <<< (TRIG_SHIFT - FRAC_BITS);
        n_s0_flip = 1'b0;
        n_s0_z    = n_s0_zraw;
        if (n_s0_zraw > Z_HALF_PI) begin
            n_s0_z    = n_s0_zraw - Z_PI;
            n_s0_flip = 1'b1;
        end else if (n_s0_zraw < -Z_HALF_PI) begin
            n_s0_z    = n_s0_zraw + Z_PI;
            n_s0_flip = 1'b1;
        end

        // vector to rotate and translation to add afterwards
        if (i_req_type == REQ_BETWEEN) begin
            n_s0_v1 = VW'(i_b_x) - VW'(i_a_x);
            n_s0_v2 = VW'(i_b_y) - VW'(i_a_y);
            n_s0_tx = '0;
            n_s0_ty = '0;
        end else begin
            n_s0_v1 = VW'(i_b_x);
            n_s0_v2 = VW'(i_b_y);
            n_s0_tx = i_a_x;
            n_s0_ty = i_a_y;
        end

        // raw heading, wrapped later
        case (i_req_type)
            REQ_COMPOSE: n_s0_th = TH_W'(i_a_theta) + TH_W'(i_b_theta);
            REQ_BETWEEN: n_s0_th = TH_W'(i_b_theta) - TH_W'(i_a_theta);
            default:     n_s0_th = '0;
        endcase
    end

    assign w_rdy0  = !r_s0_vld || w_c_rdy;
    assign o_ready = w_rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_rdy0) begin
            r_s0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_valid) begin
            r_s0_z    <= n_s0_z;
            r_s0_side <= {i_req_type, n_s0_flip, n_s0_v1, n_s0_v2,
                          n_s0_tx, n_s0_ty, n_s0_th};
        end
    end

    // ------------------------------------------------------------------
    // cordic: cosine and sine of the reduced angle
    // ------------------------------------------------------------------
    logic                     w_c_vld;
    logic signed [TRIG_W-1:0] w_c_cos;
    logic signed [TRIG_W-1:0] w_c_sin;
    logic [SIDE_W-1:0]        w_c_side;

    ppt_cordic #(
        .Z_W    (Z_W),
        .SIDE_W (SIDE_W)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_vld),
        .o_ready (w_c_rdy),
        .i_z     (r_s0_z),
        .i_side  (r_s0_side),
        .o_valid (w_c_vld),
        .i_ready (w_rdy1),
        .o_cos   (w_c_cos),
        .o_sin   (w_c_sin),
        .o_side  (w_c_side)
    );

    t_req                    w_c_op;
    logic                    w_c_flip;
    logic signed [VW-1:0]    w_c_v1;
    logic signed [VW-1:0]    w_c_v2;
    logic signed [PW-1:0]    w_c_tx;
    logic signed [PW-1:0]    w_c_ty;
    logic signed [TH_W-1:0]  w_c_th;

    assign {w_c_op, w_c_flip, w_c_v1, w_c_v2, w_c_tx, w_c_ty, w_c_th} = w_c_side;

    // ------------------------------------------------------------------
    // stage 1: trig signs per request, heading wrap
    // ------------------------------------------------------------------
    logic                     r_s1_vld;
    t_req                     r_s1_op;
    logic signed [TRIG_W-1:0] r_s1_cs;
    logic signed [TRIG_W-1:0] r_s1_s1;
    logic signed [TRIG_W-1:0] r_s1_s2;
    logic signed [VW-1:0]     r_s1_v1;
    logic signed [VW-1:0]     r_s1_v2;
    logic signed [PW-1:0]     r_s1_tx;
    logic signed [PW-1:0]     r_s1_ty;
    logic signed [ANG_WIDTH-1:0] r_s1_th;

    logic                     n_s1_neg;
    logic signed [TH_W-1:0]   n_s1_th;

    always_comb begin
        // x uses +sin for between and -sin otherwise; y takes the opposite
        n_s1_neg = w_c_flip ^ (w_c_op != REQ_BETWEEN);
        n_s1_th  = w_c_th;
        if (w_c_th > TH_PI) begin
            n_s1_th = w_c_th - TH_2PI;
        end else if (w_c_th <= -TH_PI) begin
            n_s1_th = w_c_th + TH_2PI;
        end
    end

    assign w_rdy1 = !r_s1_vld || w_rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_rdy1) begin
            r_s1_vld <= w_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && w_c_vld) begin
            r_s1_op <= w_c_op;
            r_s1_cs <= w_c_flip ? -w_c_cos : w_c_cos;
            r_s1_s1 <= n_s1_neg ? -w_c_sin : w_c_sin;
            r_s1_s2 <= n_s1_neg ? w_c_sin : -w_c_sin;
            r_s1_v1 <= w_c_v1;
            r_s1_v2 <= w_c_v2;
            r_s1_tx <= w_c_tx;
            r_s1_ty <= w_c_ty;
            r_s1_th <= n_s1_th[ANG_WIDTH-1:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: split products, high signed half and low unsigned half
    // ------------------------------------------------------------------
    logic signed [HI_W-1:0] w_v1h, w_v2h;
    logic signed [LO_W:0]   w_v1l, w_v2l;

    assign w_v1h = r_s1_v1[VW-1:LO_W];
    assign w_v2h = r_s1_v2[VW-1:LO_W];
    assign w_v1l = {1'b0, r_s1_v1[LO_W-1:0]};
    assign w_v2l = {1'b0, r_s1_v2[LO_W-1:0]};

    logic                     r_s2_vld;
    t_req                     r_s2_op;
    logic signed [PH_W-1:0]   r_s2_pxh1, r_s2_pxh2, r_s2_pyh1, r_s2_pyh2;
    logic signed [PL_W-1:0]   r_s2_pxl1, r_s2_pxl2, r_s2_pyl1, r_s2_pyl2;
    logic signed [PW-1:0]     r_s2_tx;
    logic signed [PW-1:0]     r_s2_ty;
    logic signed [ANG_WIDTH-1:0] r_s2_th;

    assign w_rdy2 = !r_s2_vld || w_rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_rdy2) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_s1_vld) begin
            r_s2_op   <= r_s1_op;
            r_s2_pxh1 <= w_v1h * r_s1_cs;
            r_s2_pxh2 <= w_v2h * r_s1_s1;
            r_s2_pxl1 <= w_v1l * r_s1_cs;
            r_s2_pxl2 <= w_v2l * r_s1_s1;
            r_s2_pyh1 <= w_v1h * r_s1_s2;
            r_s2_pyh2 <= w_v2h * r_s1_cs;
            r_s2_pyl1 <= w_v1l * r_s1_s2;
            r_s2_pyl2 <= w_v2l * r_s1_cs;
            r_s2_tx   <= r_s1_tx;
            r_s2_ty   <= r_s1_ty;
            r_s2_th   <= r_s1_th;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: pairwise sums, rounding half added on the low side
    // ------------------------------------------------------------------
    logic                     r_s3_vld;
    t_req                     r_s3_op;
    logic signed [H3_W-1:0]   r_s3_hx, r_s3_hy;
    logic signed [L3_W-1:0]   r_s3_lx, r_s3_ly;
    logic signed [PW-1:0]     r_s3_tx;
    logic signed [PW-1:0]     r_s3_ty;
    logic signed [ANG_WIDTH-1:0] r_s3_th;

    assign w_rdy3 = !r_s3_vld || w_rdy4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_rdy3) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_s2_vld) begin
            r_s3_op <= r_s2_op;
            r_s3_hx <= H3_W'(r_s2_pxh1) + H3_W'(r_s2_pxh2);
            r_s3_hy <= H3_W'(r_s2_pyh1) + H3_W'(r_s2_pyh2);
            r_s3_lx <= L3_W'(r_s2_pxl1) + L3_W'(r_s2_pxl2) + L_RND;
            r_s3_ly <= L3_W'(r_s2_pyl1) + L3_W'(r_s2_pyl2) + L_RND;
            r_s3_tx <= r_s2_tx;
            r_s3_ty <= r_s2_ty;
            r_s3_th <= r_s2_th;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: join halves and drop the trig fraction bits
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]  w_accx, w_accy;

    assign w_accx = (ACC_W'(r_s3_hx) <<< LO_W) + ACC_W'(r_s3_lx);
    assign w_accy = (ACC_W'(r_s3_hy) <<< LO_W) + ACC_W'(r_s3_ly);

    logic                     r_s4_vld;
    t_req                     r_s4_op;
    logic signed [R_W-1:0]    r_s4_rx, r_s4_ry;
    logic signed [PW-1:0]     r_s4_tx;
    logic signed [PW-1:0]     r_s4_ty;
    logic signed [ANG_WIDTH-1:0] r_s4_th;

    assign w_rdy4 = !r_s4_vld || w_rdy_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (w_rdy4) begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && r_s3_vld) begin
            r_s4_op <= r_s3_op;
            r_s4_rx <= w_accx[ACC_W-1:TRIG_SHIFT];
            r_s4_ry <= w_accy[ACC_W-1:TRIG_SHIFT];
            r_s4_tx <= r_s3_tx;
            r_s4_ty <= r_s3_ty;
            r_s4_th <= r_s3_th;
        end
    end

    // ------------------------------------------------------------------
    // output stage: translate, saturate, clear for the reserved code
    // ------------------------------------------------------------------
    logic                        r_o_vld;
    t_req                        r_o_op;
    logic signed [PW-1:0]        r_o_x;
    logic signed [PW-1:0]        r_o_y;
    logic signed [ANG_WIDTH-1:0] r_o_th;
    logic                        r_o_sat;

    logic signed [F_W-1:0]       n_fx, n_fy;
    logic signed [PW-1:0]        n_ox, n_oy;
    logic signed [ANG_WIDTH-1:0] n_oth;
    logic                        n_osat;

    always_comb begin
        n_fx   = F_W'(r_s4_rx) + F_W'(r_s4_tx);
        n_fy   = F_W'(r_s4_ry) + F_W'(r_s4_ty);
        n_osat = 1'b0;
        n_ox   = n_fx[PW-1:0];
        n_oy   = n_fy[PW-1:0];
        n_oth  = r_s4_th;
        if (n_fx > F_PMAX) begin
            n_ox   = PMAX;
            n_osat = 1'b1;
        end else if (n_fx < F_PMIN) begin
            n_ox   = PMIN;
            n_osat = 1'b1;
        end
        if (n_fy > F_PMAX) begin
            n_oy   = PMAX;
            n_osat = 1'b1;
        end else if (n_fy < F_PMIN) begin
            n_oy   = PMIN;
            n_osat = 1'b1;
        end
        if (r_s4_op == REQ_RSVD) begin
            n_ox   = '0;
            n_oy   = '0;
            n_oth  = '0;
            n_osat = 1'b0;
        end
    end

    assign w_rdy_out = !r_o_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_rdy_out) begin
            r_o_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_out && r_s4_vld) begin
            r_o_op  <= r_s4_op;
            r_o_x   <= n_ox;
            r_o_y   <= n_oy;
            r_o_th  <= n_oth;
            r_o_sat <= n_osat;
        end
    end

    assign o_valid     = r_o_vld;
    assign o_out_x     = r_o_x;
    assign o_out_y     = r_o_y;
    assign o_out_theta = r_o_th;
    assign o_saturated = r_o_sat;

    // checks
    `ASSERT_ALWAYS(a_reset_no_result, !i_rst_n |=> !o_valid, "result valid right after reset")
    `ASSERT_CLK(a_sat_at_limit, (o_valid && o_saturated) |-> (o_out_x == PMAX || o_out_x == PMIN || o_out_y == PMAX || o_out_y == PMIN), "saturation flag without a clipped coordinate")
    `ASSERT_CLK(a_point_heading, (o_valid && (r_o_op == REQ_POINT || r_o_op == REQ_RSVD)) |-> (o_out_theta == '0), "heading not zero for a point or reserved request")

endmodule
